// ===== hw/rtl/ucd_pkg.sv =====
// ---------------------------------------------------------------------------
// ucd_pkg: shared types and constants for the contention delay pipeline
// Field widths, register codes, contention decode constants and the phase
// delay table used by the front stage, the modulo stages and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucd_pkg;

   // field widths
   localparam int AddrWidth      = 16;
   localparam int TickWidth      = 17;
   localparam int BorderWidth    = 8;
   localparam int LineWidth      = 9;
   localparam int WaitWidth      = 3;
   localparam int SumWidth       = TickWidth + 1;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 17;

   // modulo pipeline shape: one dividend bit per step
   localparam int StepsPerStage  = 3;
   localparam int NumModStages   = SumWidth / StepsPerStage;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] RegDisplayStart = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegDisplayEnd   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegLeftBorder   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegScreen       = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegLine         = 3'd4;

   // register reset values
   localparam logic [TickWidth-1:0]   ResetDisplayStart = 17'd8936;
   localparam logic [TickWidth-1:0]   ResetDisplayEnd   = 17'd51944;
   localparam logic [BorderWidth-1:0] ResetLeftBorder   = 8'd24;
   localparam logic [BorderWidth-1:0] ResetScreen       = 8'd128;
   localparam logic [LineWidth-1:0]   ResetLine         = 9'd224;

   // contended ranges and ports
   localparam logic [AddrWidth-1:0] MemLow  = 16'h4000;
   localparam logic [AddrWidth-1:0] MemHigh = 16'h7FFF;
   localparam logic [7:0]           PortHsr = 8'hF4;
   localparam logic [7:0]           PortUla = 8'hFE;
   localparam logic [7:0]           PortDec = 8'hFF;

   localparam logic [WaitWidth-1:0] MaxDelay = 3'd6;

   // one word in flight through the modulo stages
   typedef struct packed {
      logic                 valid;
      logic                 live;   // contended, in display area, line length nonzero
      logic [LineWidth-1:0] rem;    // partial remainder, below line length when line length nonzero
      logic [SumWidth-1:0]  dvd;    // dividend bits not yet consumed, MSB first
   } item_type;

   // delay by line phase (position mod 8)
   function automatic logic [WaitWidth-1:0] phase_delay(input logic [2:0] phase);
      logic [WaitWidth-1:0] d;
      unique case (phase)
         3'd0:    d = 3'd5;
         3'd1:    d = 3'd4;
         3'd2:    d = 3'd3;
         3'd3:    d = 3'd2;
         3'd4:    d = 3'd1;
         3'd5:    d = 3'd0;
         3'd6:    d = 3'd0;
         default: d = 3'd6;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ucd_front.sv =====
// ---------------------------------------------------------------------------
// ucd_front: access decode and line position sum
// Registers one accepted word, flags whether it can be delayed at all and
// forms frame_tick + left border as the dividend for the modulo stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucd_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             req_valid,
   input  wire logic                             req_func,
   input  wire logic [ucd_pkg::AddrWidth-1:0]    req_bus_address,
   input  wire logic [ucd_pkg::TickWidth-1:0]    req_frame_tick,
   input  wire logic [ucd_pkg::TickWidth-1:0]    display_start,
   input  wire logic [ucd_pkg::TickWidth-1:0]    display_end,
   input  wire logic [ucd_pkg::BorderWidth-1:0]  left_border,
   input  wire logic [ucd_pkg::LineWidth-1:0]    line_len,
   output ucd_pkg::item_type                     item_out
);

   logic               contended;
   logic               in_display;
   ucd_pkg::item_type  item_in;
   ucd_pkg::item_type  item_ff;

   // contention decode: memory window or one of the video ports
   always_comb begin
      if (req_func) begin
         contended = (req_bus_address[7:0] == ucd_pkg::PortHsr) ||
                     (req_bus_address[7:0] == ucd_pkg::PortUla) ||
                     (req_bus_address[7:0] == ucd_pkg::PortDec);
      end else begin
         contended = (req_bus_address >= ucd_pkg::MemLow) &&
                     (req_bus_address <= ucd_pkg::MemHigh);
      end
   end

   // top and bottom border check
   assign in_display = (req_frame_tick >= display_start) && (req_frame_tick < display_end);

   always_comb begin
      item_in.valid = req_valid;
      item_in.live  = contended && in_display && (line_len != '0);
      item_in.rem   = '0;
      item_in.dvd   = {1'b0, req_frame_tick} +
                      {{(ucd_pkg::SumWidth-ucd_pkg::BorderWidth){1'b0}}, left_border};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff.valid <= item_in.valid;
      end
      if (advance) begin
         item_ff.live <= item_in.live;
         item_ff.rem  <= item_in.rem;
         item_ff.dvd  <= item_in.dvd;
      end
   end

   assign item_out = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ucd_mod_stage.sv =====
// ---------------------------------------------------------------------------
// ucd_mod_stage: one register stage of the line position modulo
// Restoring remainder steps, one dividend bit each: shift the next bit into
// the partial remainder and subtract the line length when it fits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucd_mod_stage (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic [ucd_pkg::LineWidth-1:0]  line_len,
   input  wire ucd_pkg::item_type              item_in,
   output ucd_pkg::item_type                   item_out
);

   logic [ucd_pkg::LineWidth-1:0] rem_v;
   logic [ucd_pkg::SumWidth-1:0]  dvd_v;
   logic [ucd_pkg::LineWidth:0]   trial_v;
   ucd_pkg::item_type             item_nx_in;
   ucd_pkg::item_type             item_ff;

   // compare-subtract chain for this stage's bits
   always_comb begin
      rem_v   = item_in.rem;
      dvd_v   = item_in.dvd;
      trial_v = '0;
      for (int s = 0; s < ucd_pkg::StepsPerStage; s++) begin
         trial_v = {rem_v, dvd_v[ucd_pkg::SumWidth-1]};
         dvd_v   = {dvd_v[ucd_pkg::SumWidth-2:0], 1'b0};
         if (trial_v >= {1'b0, line_len}) begin
            trial_v = trial_v - {1'b0, line_len};
         end
         rem_v = trial_v[ucd_pkg::LineWidth-1:0];
      end
      item_nx_in.valid = item_in.valid;
      item_nx_in.live  = item_in.live;
      item_nx_in.rem   = rem_v;
      item_nx_in.dvd   = dvd_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff.valid <= item_nx_in.valid;
      end
      if (advance) begin
         item_ff.live <= item_nx_in.live;
         item_ff.rem  <= item_nx_in.rem;
         item_ff.dvd  <= item_nx_in.dvd;
      end
   end

   assign item_out = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ula_contention_delay.sv =====
// Pipeline: a word accepted at a clock edge loads the decode stage, then
//   moves through 6 modulo stages and the output register.
// Throughput: one word per cycle unless stalled; the line length modulo runs
//   as 18 restoring steps, 3 per stage; every stage takes a word each cycle.
// Reset: synchronous; empties the pipeline and loads the timing registers
//   with their defaults (224-tick lines, 24-tick left border, 128-tick screen).
// ---------------------------------------------------------------------------
// ula_contention_delay: video fetch wait states for one bus access
// Decodes the access, takes the line position modulo the line length in a
// pipelined divider and looks up the delay from the fetch phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ula_contention_delay (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_write,
   input  wire logic [ucd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [ucd_pkg::CsrDataWidth-1:0]    csr_wdata,
   // access words
   input  wire logic                                req_valid,
   output wire logic                                req_stall,
   input  wire logic                                req_func,
   input  wire logic [ucd_pkg::AddrWidth-1:0]       req_bus_address,
   input  wire logic [ucd_pkg::TickWidth-1:0]       req_frame_tick,
   // result words
   output wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output wire logic [ucd_pkg::WaitWidth-1:0]       rsp_wait_states
);

   localparam int PosWidth = ucd_pkg::LineWidth + 1;

   logic [ucd_pkg::TickWidth-1:0]   display_start_ff;
   logic [ucd_pkg::TickWidth-1:0]   display_end_ff;
   logic [ucd_pkg::BorderWidth-1:0] left_border_ff;
   logic [ucd_pkg::BorderWidth-1:0] screen_ff;
   logic [ucd_pkg::LineWidth-1:0]   line_ff;

   logic                            advance;
   ucd_pkg::item_type               chain [0:ucd_pkg::NumModStages];
   ucd_pkg::item_type               last;

   logic [PosWidth-1:0]             pos_p1;
   logic [PosWidth-1:0]             win_end;
   logic                            in_window;
   logic [ucd_pkg::WaitWidth-1:0]   wait_in;
   logic                            rsp_valid_ff;
   logic [ucd_pkg::WaitWidth-1:0]   rsp_wait_ff;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         display_start_ff <= ucd_pkg::ResetDisplayStart;
         display_end_ff   <= ucd_pkg::ResetDisplayEnd;
         left_border_ff   <= ucd_pkg::ResetLeftBorder;
         screen_ff        <= ucd_pkg::ResetScreen;
         line_ff          <= ucd_pkg::ResetLine;
      end else if (csr_write) begin
         unique case (csr_index)
            ucd_pkg::RegDisplayStart: display_start_ff <= csr_wdata;
            ucd_pkg::RegDisplayEnd:   display_end_ff   <= csr_wdata;
            ucd_pkg::RegLeftBorder:   left_border_ff   <= csr_wdata[ucd_pkg::BorderWidth-1:0];
            ucd_pkg::RegScreen:       screen_ff        <= csr_wdata[ucd_pkg::BorderWidth-1:0];
            ucd_pkg::RegLine:         line_ff          <= csr_wdata[ucd_pkg::LineWidth-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless a finished word is held at the output
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   ucd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .req_valid       (req_valid),
      .req_func        (req_func),
      .req_bus_address (req_bus_address),
      .req_frame_tick  (req_frame_tick),
      .display_start   (display_start_ff),
      .display_end     (display_end_ff),
      .left_border     (left_border_ff),
      .line_len        (line_ff),
      .item_out        (chain[0])
   );

   // modulo stages
   for (genvar g = 0; g < ucd_pkg::NumModStages; g++) begin : g_mod
      ucd_mod_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .line_len (line_ff),
         .item_in  (chain[g]),
         .item_out (chain[g+1])
      );
   end

   assign last = chain[ucd_pkg::NumModStages];

   // fetch window: left-1 <= pos < left+screen-1, compared as pos+1
   assign pos_p1    = {1'b0, last.rem} + PosWidth'(1);
   assign win_end   = PosWidth'(left_border_ff) + PosWidth'(screen_ff);
   assign in_window = (pos_p1 >= PosWidth'(left_border_ff)) && (pos_p1 < win_end);
   assign wait_in   = (last.live && in_window) ? ucd_pkg::phase_delay(last.rem[2:0]) : '0;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last.valid;
      end
      if (advance) begin
         rsp_wait_ff <= wait_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wait_states = rsp_wait_ff;

   // a held result freezes the input side
   a_hold_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken while result held");

   // a word that cannot be delayed leaves with zero wait states
   a_dead_word_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && last.valid && !last.live) |=> (rsp_wait_ff == '0))
      else $error("nonzero delay on uncontended word");

   // delay never exceeds the table maximum
   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_wait_ff <= ucd_pkg::MaxDelay))
      else $error("delay out of range");

   // modulo remainder stays below the line length
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (last.valid && last.live) |-> (last.rem < line_ff))
      else $error("line position not reduced");

   // empty pipeline right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

`default_nettype wire
